### hw/rtl/fir_convolver_core_macros.svh
// Assertion macros shared by the FIR convolver RTL.
`ifndef FIR_CONVOLVER_CORE_MACROS_SVH
`define FIR_CONVOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FIRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FIRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define FIRC_ASSERT(lbl, clk, rst_n, prop)
`define FIRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/firc_pkg.sv
// Types and constants of the FIR convolver.
package firc_pkg;

    localparam int REQ_W     = 2;
    localparam int TAP_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W     = 64;

    localparam logic [REQ_W-1:0] REQ_CODE_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CODE_COEF   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CODE_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'd1;

    localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 14'd64;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_COEF,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_REDUCE,
        S_ROUND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_status;

endpackage

### hw/rtl/fir_convolver_core.sv
// Top level of the direct-form FIR convolver.
// Input channel (i_valid/o_ready) takes one request word per accept: a sample,
// a coefficient write or a history clear; request type 3 is dropped.
// Output channel (o_valid/i_ready) returns one word per sample.
// Configuration: i_cfg_we writes register i_cfg_index (0 enable, 1 tap_count).
// Bypassed samples go to the output register once it is free.
// A filtered sample runs G groups of lane MACs over the banked tap memories,
// G = taps / MAC_LANES, then drains the MAC pipeline, sums the L = MAC_LANES
// lane accumulators, and rounds and outputs the result.
// Coefficient writes are done in the idle state; a history clear sweeps all
// MAX_TAPS / MAC_LANES rows (1024 at defaults), one row of every bank per cycle.
// After reset the history is swept to zero the same way, and o_ready stays low
// until the sweep ends; config writes are taken throughout.
// A two-word queue splits front and back, so requests are still accepted
// while the output word waits for i_ready; the back end stalls on the output.
module fir_convolver_core
    import firc_pkg::*;
#(
    parameter int MAX_TAPS     = 8192,
    parameter int SAMPLE_WIDTH = 24,
    parameter int MAC_LANES    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [TAP_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [REQ_W-1:0]              i_req_type,
    input  logic [SAMPLE_WIDTH-1:0]       i_sample_in,
    input  logic [$clog2(MAX_TAPS)-1:0]   i_coef_index,
    input  logic [SAMPLE_WIDTH-1:0]       i_coef_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [SAMPLE_WIDTH-1:0]       o_sample_out
);
    localparam int AW = $clog2(MAX_TAPS);

    logic             r_enable;
    logic [TAP_W-1:0] r_tap_count;

    t_back_status            stat;
    logic                    q_valid;
    t_op                     q_op;
    logic [SAMPLE_WIDTH-1:0] q_sample;
    logic [AW-1:0]           q_index;
    logic [SAMPLE_WIDTH-1:0] q_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_tap_count <= TAP_COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                CFG_TAP_COUNT: r_tap_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    firc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .AW(AW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_stat       (stat),
        .o_q_valid    (q_valid),
        .o_q_op       (q_op),
        .o_q_sample   (q_sample),
        .o_q_index    (q_index),
        .o_q_value    (q_value)
    );

    firc_back #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAC_LANES    (MAC_LANES),
        .AW           (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (r_enable),
        .i_tap_count  (r_tap_count),
        .i_q_valid    (q_valid),
        .i_q_op       (q_op),
        .i_q_sample   (q_sample),
        .i_q_index    (q_index),
        .i_q_value    (q_value),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out)
    );
endmodule

### hw/rtl/firc_ram.sv
// Generic simple dual-port RAM with registered read.
module firc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/firc_front.sv
// Front end: accepts request words, classifies them and queues them.
module firc_front
    import firc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int AW           = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic [AW-1:0]           i_coef_index,
    input  logic [SAMPLE_WIDTH-1:0] i_coef_value,
    input  t_back_status            i_stat,
    output logic                    o_q_valid,
    output t_op                     o_q_op,
    output logic [SAMPLE_WIDTH-1:0] o_q_sample,
    output logic [AW-1:0]           o_q_index,
    output logic [SAMPLE_WIDTH-1:0] o_q_value
);
`include "fir_convolver_core_macros.svh"

    logic [1:0]              r_count;
    logic                    r_wr;
    logic                    r_rd;
    t_op                     r_op  [2];
    logic [SAMPLE_WIDTH-1:0] r_smp [2];
    logic [AW-1:0]           r_idx [2];
    logic [SAMPLE_WIDTH-1:0] r_val [2];

    t_op  op;
    logic op_ok;
    logic push;
    logic pop;

    always_comb begin
        op    = OP_SAMPLE;
        op_ok = 1'b1;
        unique case (i_req_type)
            REQ_CODE_SAMPLE: op = OP_SAMPLE;
            REQ_CODE_COEF:   op = OP_COEF;
            REQ_CODE_CLEAR:  op = OP_CLEAR;
            default:         op_ok = 1'b0;
        endcase
    end

    assign o_ready = (r_count != 2'd2) && !i_stat.init_busy;
    assign push    = i_valid && o_ready && op_ok;
    assign pop     = i_stat.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr]  <= op;
            r_smp[r_wr] <= i_sample_in;
            r_idx[r_wr] <= i_coef_index;
            r_val[r_wr] <= i_coef_value;
        end
    end

    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_op     = r_op[r_rd];
    assign o_q_sample = r_smp[r_rd];
    assign o_q_index  = r_idx[r_rd];
    assign o_q_value  = r_val[r_rd];

    `FIRC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_count <= 2'd2)
    `FIRC_ASSERT(a_no_pop_empty, i_clk, i_rst_n, pop |-> (r_count != 2'd0))
    `FIRC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (r_count == 2'd0))
endmodule

### hw/rtl/firc_back.sv
// Back end: history and coefficient banks, MAC lanes, reduction and rounding.
module firc_back
    import firc_pkg::*;
#(
    parameter int MAX_TAPS     = 8192,
    parameter int SAMPLE_WIDTH = 24,
    parameter int MAC_LANES    = 8,
    parameter int AW           = $clog2(MAX_TAPS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_enable,
    input  logic [TAP_W-1:0]        i_tap_count,
    input  logic                    i_q_valid,
    input  t_op                     i_q_op,
    input  logic [SAMPLE_WIDTH-1:0] i_q_sample,
    input  logic [AW-1:0]           i_q_index,
    input  logic [SAMPLE_WIDTH-1:0] i_q_value,
    output t_back_status            o_stat,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample_out
);
`include "fir_convolver_core_macros.svh"

    localparam int LB   = $clog2(MAC_LANES);
    localparam int LW   = (MAC_LANES > 1) ? LB : 1;
    localparam int ROWS = MAX_TAPS / MAC_LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW   = (AW + 1 > TAP_W) ? AW + 1 : TAP_W;
    localparam int PW   = 2 * SAMPLE_WIDTH;
    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (SAMPLE_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] HI_V    = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] LO_V    = -HI_V - ACC_W'(1);

    t_state r_state, n_state;

    logic                    r_init;
    logic [RW-1:0]           r_clr_row;
    logic [AW-1:0]           r_wp;
    logic [RW-1:0]           r_k;
    logic [RW-1:0]           r_klast;
    logic                    r_v1, r_v2;
    logic [LW-1:0]           r_ridx;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_data;
    logic signed [ACC_W-1:0] r_sum;
    logic [SAMPLE_WIDTH-1:0] r_res;
    logic signed [PW-1:0]    r_prod [MAC_LANES];
    logic signed [ACC_W-1:0] r_acc  [MAC_LANES];

    logic [SAMPLE_WIDTH-1:0] hist_rd [MAC_LANES];
    logic [SAMPLE_WIDTH-1:0] coef_rd [MAC_LANES];

    logic q_pop, hist_wr, coef_wr, clr_wr, mac_start, issue;
    logic red_step, do_round, load_out, load_bypass, wp_step, clr_start;
    logic out_free;

    logic [NW-1:0]           n_taps;
    logic [NW-1:0]           groups;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] sat;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        q_pop       = 1'b0;
        hist_wr     = 1'b0;
        coef_wr     = 1'b0;
        clr_wr      = 1'b0;
        clr_start   = 1'b0;
        mac_start   = 1'b0;
        issue       = 1'b0;
        red_step    = 1'b0;
        do_round    = 1'b0;
        load_out    = 1'b0;
        load_bypass = 1'b0;
        wp_step     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                clr_wr = 1'b1;
                if (r_clr_row == RW'(ROWS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_op)
                        OP_COEF: begin
                            q_pop   = 1'b1;
                            coef_wr = 1'b1;
                        end
                        OP_CLEAR: begin
                            q_pop     = 1'b1;
                            clr_start = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        OP_SAMPLE: begin
                            if (!i_enable) begin
                                if (out_free) begin
                                    q_pop       = 1'b1;
                                    load_bypass = 1'b1;
                                end
                            end else begin
                                q_pop     = 1'b1;
                                hist_wr   = 1'b1;
                                mac_start = 1'b1;
                                n_state   = S_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC: begin
                issue = 1'b1;
                if (r_k == r_klast) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) n_state = S_REDUCE;
            end
            S_REDUCE: begin
                red_step = 1'b1;
                if (r_ridx == LW'(MAC_LANES - 1)) n_state = S_ROUND;
            end
            S_ROUND: begin
                do_round = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    wp_step  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // effective tap count in groups of MAC_LANES
    always_comb begin
        n_taps = NW'(i_tap_count);
        if (n_taps > NW'(MAX_TAPS))  n_taps = NW'(MAX_TAPS);
        if (n_taps < NW'(MAC_LANES)) n_taps = NW'(MAC_LANES);
        groups = n_taps >> LB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_clr_row   <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (clr_start) r_clr_row <= '0;
            else if (clr_wr) r_clr_row <= r_clr_row + RW'(1);
            if (clr_wr && r_clr_row == RW'(ROWS - 1)) r_init <= 1'b0;
            if (wp_step) r_wp <= r_wp - AW'(1);
            if (mac_start) r_k <= '0;
            else if (issue) r_k <= r_k + RW'(1);
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (mac_start) r_ridx <= '0;
            else if (red_step) r_ridx <= r_ridx + LW'(1);
            if (load_out || load_bypass) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_start) r_klast <= RW'(groups - NW'(1));
        if (mac_start) r_sum <= ROUND_C;
        else if (red_step) r_sum <= r_sum + r_acc[r_ridx];
        if (do_round) r_res <= SAMPLE_WIDTH'(sat);
        if (load_bypass) r_out_data <= i_q_sample;
        else if (load_out) r_out_data <= r_res;
    end

    always_comb begin
        shifted = r_sum >>> (SAMPLE_WIDTH - 1);
        sat     = shifted;
        if (shifted > HI_V) sat = HI_V;
        if (shifted < LO_V) sat = LO_V;
    end

    for (genvar b = 0; b < MAC_LANES; b++) begin : g_bank
        logic [LW-1:0] jb;
        logic [AW-1:0] raddr;
        logic          h_we;
        logic [RW-1:0] h_waddr;
        logic [SAMPLE_WIDTH-1:0] h_wdata;
        logic          c_we;

        assign jb      = LW'((AW'(b) - r_wp) % MAC_LANES);
        assign raddr   = r_wp + (AW'(r_k) << LB) + AW'(jb);
        assign h_we    = clr_wr || (hist_wr && (LW'(r_wp % MAC_LANES) == LW'(b)));
        assign h_waddr = clr_wr ? r_clr_row : RW'(r_wp >> LB);
        assign h_wdata = clr_wr ? '0 : i_q_sample;
        assign c_we    = coef_wr && (LW'(i_q_index % MAC_LANES) == LW'(b));

        firc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(ROWS)) u_hist (
            .i_clk   (i_clk),
            .i_we    (h_we),
            .i_waddr (h_waddr),
            .i_wdata (h_wdata),
            .i_raddr (RW'(raddr >> LB)),
            .o_rdata (hist_rd[b])
        );

        firc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(ROWS)) u_coef (
            .i_clk   (i_clk),
            .i_we    (c_we),
            .i_waddr (RW'(i_q_index >> LB)),
            .i_wdata (i_q_value),
            .i_raddr (r_k),
            .o_rdata (coef_rd[b])
        );
    end

    for (genvar j = 0; j < MAC_LANES; j++) begin : g_lane
        logic [LW-1:0]                  sel;
        logic signed [SAMPLE_WIDTH-1:0] h;
        logic signed [SAMPLE_WIDTH-1:0] c;

        assign sel = LW'((r_wp + AW'(j)) % MAC_LANES);
        assign h   = hist_rd[sel];
        assign c   = coef_rd[j];

        always_ff @(posedge i_clk) begin
            if (r_v1) r_prod[j] <= h * c;
            if (mac_start) r_acc[j] <= '0;
            else if (r_v2) r_acc[j] <= r_acc[j] + ACC_W'(r_prod[j]);
        end
    end

    assign o_stat.pop       = q_pop;
    assign o_stat.init_busy = r_init;
    assign o_valid          = r_out_valid;
    assign o_sample_out     = r_out_data;

    `FIRC_ASSERT(a_k_bound, i_clk, i_rst_n, (r_state == S_MAC) |-> (r_k <= r_klast))
    `FIRC_ASSERT(a_wp_step, i_clk, i_rst_n,
        ($past(i_rst_n) && (r_wp != $past(r_wp))) |-> ($past(r_state) == S_OUT))
    `FIRC_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_data)))
endmodule

### sim/fir_convolver_core_test.sv
// Testbench for fir_convolver_core: scoreboarded FIR prediction under random traffic.
module fir_convolver_core_test;
    import firc_pkg::*;

    localparam int NTAPS = 8192;
    localparam int SW = 24;
    localparam int SETTLE = 1200;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int COEF_LOAD = 64;
    localparam logic [REQ_W-1:0] REQ_CODE_UNUSED = 2'd3;
    localparam logic [SW-1:0] S_MAX = 24'h7FFFFF;
    localparam logic [SW-1:0] S_MIN = 24'h800000;

    class fir_scoreboard;
        logic signed [SW-1:0] hist [NTAPS];
        logic signed [SW-1:0] coef [NTAPS];
        int unsigned wp;
        bit filt_on;
        int unsigned tap_req;
        logic [SW-1:0] want_q [$];
        int errors;

        function new();
            foreach (hist[k]) begin
                hist[k] = '0;
                coef[k] = '0;
            end
            wp = 0;
            filt_on = 0;
            tap_req = TAP_COUNT_RESET;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function int unsigned live_taps();
            int unsigned n;
            n = tap_req;
            if (n > NTAPS) n = NTAPS;
            if (n < 8) n = 8;
            n = (n / 8) * 8;
            return n;
        endfunction

        function void note(logic [REQ_W-1:0] kind, logic [SW-1:0] s,
                           logic [12:0] idx, logic [SW-1:0] v);
            longint acc;
            longint r;
            int unsigned n;
            if (kind == REQ_CODE_COEF) begin
                coef[idx] = v;
            end else if (kind == REQ_CODE_CLEAR) begin
                foreach (hist[k]) hist[k] = '0;
            end else if (kind == REQ_CODE_SAMPLE) begin
                if (!filt_on) begin
                    want_q.push_back(s);
                end else begin
                    n = live_taps();
                    hist[wp] = s;
                    acc = 0;
                    for (int unsigned t = 0; t < n; t++)
                        acc += longint'(hist[(wp + t) % NTAPS]) * longint'(coef[t]);
                    acc += longint'(1) <<< 22;
                    r = acc >>> 23;
                    if (r > 64'sd8388607) r = 64'sd8388607;
                    if (r < -64'sd8388608) r = -64'sd8388608;
                    want_q.push_back(r[SW-1:0]);
                    wp = (wp == 0) ? NTAPS - 1 : wp - 1;
                end
            end
        endfunction

        function void check(logic [SW-1:0] got);
            logic [SW-1:0] w;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            w = want_q.pop_front();
            if (got !== w) report($sformatf("sample_out %h, expected %h", got, w));
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ENABLE;
    logic [TAP_W-1:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_ready;
    logic [REQ_W-1:0] i_req_type = REQ_CODE_SAMPLE;
    logic [SW-1:0] i_sample_in = '0;
    logic [12:0] i_coef_index = '0;
    logic [SW-1:0] i_coef_value = '0;
    logic o_valid;
    logic i_ready = 0;
    logic [SW-1:0] o_sample_out;

    fir_scoreboard sb = new();
    bit idle_on = 1;
    bit hold_req = 0;
    int cycles = 0;

    fir_convolver_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready) sb.check(o_sample_out);

    initial begin : sink
        int gap;
        int hold;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 0;
                hold = 3000;
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                end
                hold_req = 0;
            end
            if (gap > 0) begin
                i_ready = 0;
                gap--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready = 0;
                gap = $urandom_range(0, 9);
            end else begin
                i_ready = 1;
            end
        end
    end

    task automatic send_word(logic [REQ_W-1:0] kind, logic [SW-1:0] s,
                             logic [12:0] idx, logic [SW-1:0] v);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid = 0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid = 1;
        i_req_type = kind;
        i_sample_in = s;
        i_coef_index = idx;
        i_coef_value = v;
        do @(posedge i_clk); while (!o_ready);
        sb.note(kind, s, idx, v);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int r;
        logic [SW-1:0] s;
        r = $urandom_range(0, 3);
        s = (r == 0) ? S_MAX : (r == 1) ? S_MIN :
            (r == 2) ? SW'($signed($urandom_range(0, 2000)) - 1000) : SW'($urandom);
        r = $urandom_range(0, 99);
        if (r < 72) send_word(REQ_CODE_SAMPLE, s, 13'($urandom), SW'($urandom));
        else if (r < 88) send_word(REQ_CODE_COEF, SW'($urandom), 13'($urandom), s);
        else if (r < 91) send_word(REQ_CODE_CLEAR, SW'($urandom), 13'($urandom), SW'($urandom));
        else send_word(REQ_CODE_UNUSED, SW'($urandom), 13'($urandom), SW'($urandom));
    endtask

    task automatic settle();
        i_valid = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [TAP_W-1:0] data);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 0;
        if (idx == CFG_ENABLE) sb.filt_on = data[0];
        else sb.tap_req = data;
    endtask

    task automatic run_phase(bit en, logic [TAP_W-1:0] taps, int count);
        settle();
        write_cfg(CFG_ENABLE, TAP_W'(en));
        write_cfg(CFG_TAP_COUNT, taps);
        for (int k = 0; k < count; k++) send_random();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        write_cfg(CFG_ENABLE, 1);
        write_cfg(CFG_TAP_COUNT, 8);
        for (int k = 0; k < COEF_LOAD; k++)
            send_word(REQ_CODE_COEF, '0, 13'(k), (k < 8) ? S_MAX : SW'($urandom));

        // saturation both ways, then the non-sample request types
        repeat (9) send_word(REQ_CODE_SAMPLE, S_MAX, '0, '0);
        repeat (9) send_word(REQ_CODE_SAMPLE, S_MIN, '0, '0);
        send_word(REQ_CODE_SAMPLE, '0, '0, '0);
        send_word(REQ_CODE_UNUSED, S_MAX, 13'd3, S_MIN);
        send_word(REQ_CODE_SAMPLE, S_MAX, '0, '0);
        send_word(REQ_CODE_CLEAR, '0, '1, S_MAX);
        send_word(REQ_CODE_SAMPLE, 24'h000001, '0, '0);
        send_word(REQ_CODE_COEF, '0, 13'd8191, S_MIN);
        send_word(REQ_CODE_COEF, '0, 13'd3, S_MIN);
        send_word(REQ_CODE_SAMPLE, S_MIN, '0, '0);

        run_phase(1, 14'd0, 5);
        run_phase(1, 14'd63, 4);
        run_phase(1, 14'd64, 4);
        run_phase(1, 14'd65, 4);
        run_phase(0, 14'd7, 20);

        settle();
        write_cfg(CFG_ENABLE, 1);
        write_cfg(CFG_TAP_COUNT, 16);
        hold_req = 1;
        for (int k = 0; k < 100; k++) send_random();
        run_phase(1, 14'd13, 90);
        run_phase(1, 14'd64, 90);
        run_phase(0, 14'd9000, 80);
        run_phase(1, 14'd40, 90);
        settle();
        idle_on = 0;
        run_phase(1, 14'd24, 90);

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
